/* sv/wsd_pkg.sv */
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by wsd_parser and websocket_frame_deframer.
`default_nettype none

package wsd_pkg;

	localparam int LENGTH_BITS = 16;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
	localparam logic [3:0] OPCODE_CLOSE = 4'h8;

	typedef enum logic [2:0] {
		PH_HDR0   = 3'd0,
		PH_HDR1   = 3'd1,
		PH_EXTLEN = 3'd2,
		PH_KEY    = 3'd3,
		PH_DATA   = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic [3:0] frame_opcode;
		logic       last_of_frame;
		logic       no_payload;
		logic       close_request;
		logic       format_error;
	} result_t;

endpackage

`default_nettype wire

/* sv/wsd_parser.sv */
// Frame parser: header, length, key and payload state, one byte per step.
// Depends on wsd_pkg.
`default_nettype none

module wsd_parser
	import wsd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] byte_in,
	output logic            res_valid,
	output result_t         res
);

	phase_t                  phase_q, phase_d;
	logic [3:0]              opcode_q, opcode_d;
	logic                    mask_q, mask_d;
	logic [LENGTH_BITS-1:0]  length_q, length_d;
	logic [1:0]              hidx_q, hidx_d;
	logic [31:0]             key_q, key_d;
	logic [15:0]             count_q, count_d;

	logic [6:0]              len_code;
	logic [15:0]             ext_len;
	logic [LENGTH_BITS-1:0]  hdr_len;
	logic [15:0]             count_inc;
	logic [7:0]              key_byte;
	logic                    is_close;

	assign len_code  = byte_in[6:0];
	assign ext_len   = {length_q[7:0], byte_in};
	assign count_inc = count_q + 16'd1;
	assign key_byte  = key_q[8*count_q[1:0] +: 8];
	assign is_close  = (opcode_q == OPCODE_CLOSE);

	always_comb begin
		phase_d   = phase_q;
		opcode_d  = opcode_q;
		mask_d    = mask_q;
		length_d  = length_q;
		hidx_d    = hidx_q;
		key_d     = key_q;
		count_d   = count_q;
		res_valid = 1'b0;
		res       = '{payload_byte: 8'h00, frame_opcode: opcode_q, last_of_frame: 1'b1,
			no_payload: 1'b0, close_request: is_close, format_error: 1'b0};
		hdr_len   = LENGTH_BITS'(len_code);

		unique case (phase_q)
			PH_HDR1: begin
				mask_d = byte_in[7];
				if (len_code == LEN_CODE_EXT64) begin
					phase_d = PH_HDR0;
					res_valid = 1'b1;
					res.close_request = 1'b0;
					res.format_error = 1'b1;
				end else if (len_code == LEN_CODE_EXT16) begin
					length_d = '0;
					hidx_d = 2'd0;
					phase_d = PH_EXTLEN;
				end else begin
					length_d = hdr_len;
					hidx_d = 2'd0;
					key_d = '0;
					count_d = '0;
					if (byte_in[7]) begin
						phase_d = PH_KEY;
					end else if (hdr_len == '0) begin
						phase_d = PH_HDR0;
						res_valid = 1'b1;
						res.no_payload = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_EXTLEN: begin
				if (hidx_q == 2'd0) begin
					length_d = '0;
					length_d[7:0] = byte_in;
					hidx_d = 2'd1;
				end else begin
					// saturate when the extended length exceeds the counter range
					if (32'(ext_len) > 32'(LEN_MAX)) begin
						length_d = LEN_MAX;
					end else begin
						length_d = LENGTH_BITS'(ext_len);
					end
					hidx_d = 2'd0;
					key_d = '0;
					count_d = '0;
					if (mask_q) begin
						phase_d = PH_KEY;
					end else if (ext_len == '0) begin
						phase_d = PH_HDR0;
						res_valid = 1'b1;
						res.no_payload = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_KEY: begin
				key_d[8*hidx_q +: 8] = key_q[8*hidx_q +: 8] | byte_in;
				if (hidx_q != 2'd3) begin
					hidx_d = hidx_q + 2'd1;
				end else begin
					hidx_d = 2'd0;
					count_d = '0;
					if (length_q == '0) begin
						phase_d = PH_HDR0;
						res_valid = 1'b1;
						res.no_payload = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				count_d = count_inc;
				res_valid = 1'b1;
				res.payload_byte = byte_in ^ key_byte;
				res.last_of_frame = (32'(count_inc) >= 32'(length_q));
				if (res.last_of_frame) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				opcode_d = byte_in[3:0];
				phase_d = PH_HDR1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			opcode_q <= '0;
			mask_q   <= 1'b0;
			length_q <= '0;
			hidx_q   <= '0;
			key_q    <= '0;
			count_q  <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			opcode_q <= opcode_d;
			mask_q   <= mask_d;
			length_q <= length_d;
			hidx_q   <= hidx_d;
			key_q    <= key_d;
			count_q  <= count_d;
		end
	end

endmodule

`default_nettype wire

/* sv/websocket_frame_deframer.sv */
// WebSocket frame deframer: one received byte per beat in, unmasked payload beats out,
// plus zero-length marker and error beats. An accepted byte is held in the input
// register, parsed when it advances, and its result is registered for the output.
// Throughput: one byte per cycle while out_ready stays high; the input register
// advances whenever it is empty or the output register is empty or being drained.
// Reset (arst_n low, asynchronous): parser expects a first header byte, pipeline empty.
// Depends on wsd_pkg and wsd_parser.
`default_nettype none

module websocket_frame_deframer
	import wsd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      payload_byte,
	output logic [3:0]      frame_opcode,
	output logic            last_of_frame,
	output logic            no_payload,
	output logic            close_request,
	output logic            format_error
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	result_t    res_s2;

	logic       out_free;
	logic       advance;
	logic       res_valid;
	result_t    res;

	assign out_free = !valid_s2 || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.byte_in   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && res_valid;
		end
	end

	// load a fresh result only when one is produced
	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign payload_byte  = res_s2.payload_byte;
	assign frame_opcode  = res_s2.frame_opcode;
	assign last_of_frame = res_s2.last_of_frame;
	assign no_payload    = res_s2.no_payload;
	assign close_request = res_s2.close_request;
	assign format_error  = res_s2.format_error;

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking bench for websocket_frame_deframer: feeds a byte stream of frames,
// predicts every payload, marker and error beat, and checks the output stream.
// Depends on wsd_pkg and the deframer RTL.

module tb_top
	import wsd_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_PCT = 38;
	localparam int RANDOM_UNTIL = 600;
	localparam int HOLD_AT = 150;
	localparam int HOLD_CYCLES = 200;
	localparam int PAUSE_AT = 320;
	localparam int CALM_LO = 420;
	localparam int CALM_HI = 560;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT = 100_000;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  opcode;
		logic        masked;
		logic [15:0] length;
		logic [1:0]  hdr_idx;
		logic [31:0] key;
		logic [15:0] count;
	} parser_state_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] payload_byte;
	logic [3:0] frame_opcode;
	logic       last_of_frame;
	logic       no_payload;
	logic       close_request;
	logic       format_error;

	logic [7:0]    stream_q [$];
	result_t       pending_results [$];
	parser_state_t stream_model;
	parser_state_t rx_parser;

	int cycle_count = 0;
	int bytes_offered = 0;
	int results_seen = 0;
	int mismatch_count = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit pausing = 1'b0;
	bit pause_done = 1'b0;
	bit in_taken = 1'b0;

	wire calm = bytes_offered >= CALM_LO && bytes_offered < CALM_HI;

	websocket_frame_deframer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.payload_byte(payload_byte),
		.frame_opcode(frame_opcode),
		.last_of_frame(last_of_frame),
		.no_payload(no_payload),
		.close_request(close_request),
		.format_error(format_error)
	);

	always #5 clk = ~clk;

	// Advance the parser by one byte; returns 1 when the byte yields a beat.
	function automatic bit deframe_byte(inout parser_state_t s, input logic [7:0] b,
			output result_t r);
		logic [7:0] key_byte;
		logic [15:0] ext_len;
		bit length_done;
		bit header_done;
		r = '0;
		r.frame_opcode = s.opcode;
		length_done = 1'b0;
		header_done = 1'b0;
		case (s.phase)
			PH_HDR1: begin
				s.masked = b[7];
				if (b[6:0] == LEN_CODE_EXT64) begin
					s.phase = PH_HDR0;
					r.last_of_frame = 1'b1;
					r.format_error = 1'b1;
					return 1'b1;
				end else if (b[6:0] == LEN_CODE_EXT16) begin
					s.length = '0;
					s.hdr_idx = '0;
					s.phase = PH_EXTLEN;
				end else begin
					s.length = {9'd0, b[6:0]};
					length_done = 1'b1;
				end
			end
			PH_EXTLEN: begin
				if (s.hdr_idx == 2'd0) begin
					s.length = {b, 8'h00};
					s.hdr_idx = 2'd1;
				end else begin
					ext_len = s.length | {8'h00, b};
					s.length = (ext_len > LEN_MAX) ? LEN_MAX : ext_len;
					length_done = 1'b1;
				end
			end
			PH_KEY: begin
				s.key = s.key | ({24'h0, b} << {s.hdr_idx, 3'b000});
				if (s.hdr_idx != 2'd3) begin
					s.hdr_idx = s.hdr_idx + 2'd1;
				end else begin
					s.hdr_idx = '0;
					header_done = 1'b1;
				end
			end
			PH_DATA: begin
				key_byte = 8'(s.key >> {s.count[1:0], 3'b000});
				s.count = s.count + 16'd1;
				r.payload_byte = b ^ key_byte;
				r.last_of_frame = s.count >= s.length;
				r.close_request = s.opcode == OPCODE_CLOSE;
				if (r.last_of_frame)
					s.phase = PH_HDR0;
				return 1'b1;
			end
			default: begin
				s.opcode = b[3:0];
				s.phase = PH_HDR1;
			end
		endcase
		if (length_done) begin
			s.hdr_idx = '0;
			s.key = '0;
			if (s.masked)
				s.phase = PH_KEY;
			else
				header_done = 1'b1;
		end
		if (header_done) begin
			s.count = '0;
			if (s.length == 16'd0) begin
				// zero-length frame: one marker beat
				s.phase = PH_HDR0;
				r.last_of_frame = 1'b1;
				r.no_payload = 1'b1;
				r.close_request = s.opcode == OPCODE_CLOSE;
				return 1'b1;
			end
			s.phase = PH_DATA;
		end
		return 1'b0;
	endfunction

	task automatic queue_byte(input logic [7:0] b);
		result_t discard;
		stream_q.push_back(b);
		void'(deframe_byte(stream_model, b, discard));
	endtask

	// Random bytes until the stream is back at a frame boundary; keep any
	// 16-bit length short so one stray header cannot swallow the stream.
	task automatic scramble(input int n);
		logic [7:0] b;
		int k;
		k = 0;
		while (k < n || stream_model.phase != PH_HDR0) begin
			b = 8'($urandom_range(255));
			if (stream_model.phase == PH_EXTLEN && stream_model.hdr_idx == 2'd0)
				b = 8'($urandom_range(1));
			queue_byte(b);
			k++;
		end
	endtask

	task automatic queue_frame(input logic [7:0] hdr0, input bit masked, input int len,
			input bit use_ext, input bit broken);
		logic [7:0] fb [$];
		int cut;
		fb.push_back(hdr0);
		if (use_ext) begin
			fb.push_back({masked, LEN_CODE_EXT16});
			fb.push_back(len[15:8]);
			fb.push_back(len[7:0]);
		end else
			fb.push_back({masked, 7'(len)});
		if (masked)
			for (int i = 0; i < 4; i++)
				fb.push_back(8'($urandom_range(255)));
		for (int i = 0; i < len; i++)
			fb.push_back(8'($urandom_range(255)));
		cut = broken ? $urandom_range(fb.size() - 1, 1) : fb.size();
		for (int i = 0; i < cut; i++)
			queue_byte(fb[i]);
		scramble(0);
	endtask

	// Driver: offer the next byte once the current one is taken.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (!pause_done && bytes_offered >= PAUSE_AT && pending_results.size() != 0)
				pausing = 1'b1;
			if (pausing && pending_results.size() == 0) begin
				pausing = 1'b0;
				pause_done = 1'b1;
			end
			if (!pausing && stream_q.size() != 0
					&& (calm || hold_left != 0 || $urandom_range(99) >= IDLE_PCT)) begin
				in_valid <= 1'b1;
				rx_byte <= stream_q.pop_front();
				bytes_offered++;
			end else
				in_valid <= 1'b0;
		end
	end

	// Receiver: random stalls, one long hold-off to back the block up.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && bytes_offered >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else
				out_ready <= calm || $urandom_range(99) >= IDLE_PCT;
		end
	end

	// Monitor: check output beats, then predict from the accepted input byte.
	always @(posedge clk) begin : monitor
		result_t got;
		result_t want;
		result_t pred;
		cycle_count++;
		in_taken <= in_valid && in_ready;
		if (out_valid && out_ready) begin
			got = {payload_byte, frame_opcode, last_of_frame, no_payload, close_request,
				format_error};
			if (pending_results.size() == 0) begin
				if (mismatch_count < 10)
					$display("beat %0d: unexpected output %h", results_seen, got);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.payload_byte !== want.payload_byte
						|| got.frame_opcode !== want.frame_opcode
						|| got.last_of_frame !== want.last_of_frame
						|| got.no_payload !== want.no_payload
						|| got.close_request !== want.close_request
						|| got.format_error !== want.format_error) begin
					if (mismatch_count < 10)
						$display({"beat %0d exp/got: byte %h/%h op %h/%h last %b/%b",
							" empty %b/%b close %b/%b err %b/%b"}, results_seen,
							want.payload_byte, got.payload_byte,
							want.frame_opcode, got.frame_opcode,
							want.last_of_frame, got.last_of_frame,
							want.no_payload, got.no_payload,
							want.close_request, got.close_request,
							want.format_error, got.format_error);
					mismatch_count++;
				end
			end
			results_seen++;
		end
		if (in_valid && in_ready) begin
			if (deframe_byte(rx_parser, rx_byte, pred))
				pending_results.push_back(pred);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("websocket_frame_deframer test failed");
		$finish;
	end

	initial begin
		logic [7:0] directed [$];
		logic [7:0] hdr0;
		bit masked;
		bit use_ext;
		int kind;
		int len;

		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		out_ready = 1'b0;
		stream_model = '0;
		stream_model.phase = PH_HDR0;
		rx_parser = '0;
		rx_parser.phase = PH_HDR0;

		directed = '{
			8'h81, 8'h02, 8'h00, 8'hFF,               // text, payload extremes
			8'hFF, 8'h00,                             // all header bits, empty frame
			8'h88, 8'h80, 8'hFF, 8'h00, 8'hA5, 8'h5A, // masked empty close
			8'h82, 8'h7F,                             // 64-bit length code
			8'h88, 8'h7E, 8'h00, 8'h00,               // empty close via 16-bit length
			8'h02, 8'hFE, 8'h00, 8'h05,               // masked, key index wraps
			8'h12, 8'h34, 8'h56, 8'h78,
			8'hFF, 8'h00, 8'h5A, 8'hA5, 8'hFF
		};
		foreach (directed[i])
			queue_byte(directed[i]);

		// Mostly well-formed frames; some errors, noise and cut-off frames.
		while (stream_q.size() < RANDOM_UNTIL) begin
			kind = $urandom_range(99);
			hdr0 = 8'($urandom_range(255));
			if ($urandom_range(4) == 0)
				hdr0[3:0] = OPCODE_CLOSE;
			masked = 1'($urandom_range(1));
			if (kind < 4) begin
				queue_byte(hdr0);
				queue_byte({masked, LEN_CODE_EXT64});
			end else if (kind < 9)
				scramble($urandom_range(4, 1));
			else begin
				if (kind < 18)
					len = 0;
				else if (kind < 70)
					len = $urandom_range(12, 1);
				else if (kind < 84)
					len = $urandom_range(125, 13);
				else if (kind < 97)
					len = $urandom_range(40, 0);
				else
					len = $urandom_range(400, 126);
				use_ext = kind >= 84;
				queue_frame(hdr0, masked, len, use_ext, $urandom_range(99) < 6);
			end
		end
		// one masked frame with a 16-bit length, then a short tail
		queue_frame(8'h82, 1'b1, 40, 1'b1, 1'b0);
		queue_frame(8'h81, 1'b0, 3, 1'b0, 1'b0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (stream_q.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("websocket_frame_deframer test passed");
		else
			$display("websocket_frame_deframer test failed");
		$finish;
	end

endmodule
